### rtl/pwm_speed_ramp_core_defines.svh
// Assertion macros shared by the speed ramp RTL.
// Standalone header; the checks compile away when SYNTHESIS is defined.
`ifndef PWM_SPEED_RAMP_CORE_DEFINES_SVH
`define PWM_SPEED_RAMP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PSR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("psr check failed");
// Next-cycle implication, checked out of reset.
`define PSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("psr check failed");
`else
`define PSR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/psr_pkg.sv
// Types, constants and helpers for the speed ramp generator.
// No dependencies; used by every module of the block.
package psr_pkg;

  // Milli-PWM values stay within +/-128000, so 18 signed bits hold them.
  localparam int MilliW = 18;
  localparam int MilliPerUnit = 1000;
  // Reciprocal of 1000 scaled by 2^27, exact for magnitudes below 2^17.
  localparam int RecipShift = 27;
  localparam logic [17:0] Recip1000 = 18'd134218;
  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  // Item kinds.
  localparam logic KindTick = 1'b0;
  localparam logic KindRestart = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_ms;
    logic signed [7:0] target_pwm;
    logic signed [15:0] acceleration;
    logic signed [7:0] left_pwm;
    logic signed [7:0] right_pwm;
  } psr_in_t;

  typedef struct packed {
    logic              drive_valid;
    logic signed [7:0] drive_pwm;
    logic              ramp_done;
  } psr_out_t;

  // Registered item after input preprocessing.
  typedef struct packed {
    logic                     kind;
    logic [31:0]              now_ms;
    logic signed [MilliW-1:0] target_milli;
    logic signed [MilliW-1:0] avg_milli;
    logic [15:0]              rate;
    logic                     hold_match;
  } psr_item_t;

  // Result before the divide by 1000.
  typedef struct packed {
    logic                     drive_valid;
    logic signed [MilliW-1:0] milli;
    logic                     done;
  } psr_res_t;

  // Scale a PWM value to milli-PWM.
  function automatic logic signed [MilliW-1:0] to_milli(input logic signed [7:0] pwm);
    logic signed [MilliW-1:0] ext;
    ext = {{(MilliW-8){pwm[7]}}, pwm};
    return ext * 18'sd1000;
  endfunction

endpackage

### rtl/psr_in_stage.sv
// Input register of the speed ramp: scales target and wheel average, takes |accel|.
// Depends on psr_pkg.
module psr_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psr_pkg::psr_in_t    in_data,
  input  logic                mid_take,
  output logic                item_valid,
  output psr_pkg::psr_item_t  item_data
);

  logic               valid_r;
  psr_pkg::psr_item_t item_r;
  psr_pkg::psr_item_t item_nxt;
  logic               take;
  logic signed [8:0]  wheel_sum;
  logic signed [8:0]  wheel_adj;
  logic signed [7:0]  avg;

  // The register frees up when empty or when its item moves on.
  assign take = !valid_r || mid_take;
  assign in_stall = !take;

  // Wheel average truncated toward zero: odd negative sums round up first.
  always_comb begin
    wheel_sum = 9'(in_data.left_pwm) + 9'(in_data.right_pwm);
    wheel_adj = wheel_sum + ((wheel_sum[8] && wheel_sum[0]) ? 9'sd1 : 9'sd0);
    avg = wheel_adj[8:1];
    item_nxt.kind = in_data.kind;
    item_nxt.now_ms = in_data.now_ms;
    item_nxt.target_milli = psr_pkg::to_milli(in_data.target_pwm);
    item_nxt.avg_milli = psr_pkg::to_milli(avg);
    item_nxt.rate = in_data.acceleration[15] ? 16'(-in_data.acceleration)
                                             : 16'(in_data.acceleration);
    item_nxt.hold_match = (avg == in_data.target_pwm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= in_valid;
    end
  end

  // Payload is captured on each input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item_data = item_r;

endmodule

### rtl/psr_ramp_stage.sv
// Ramp state machine and step arithmetic of the speed ramp generator.
// Depends on psr_pkg and the assertion macros header.
`include "pwm_speed_ramp_core_defines.svh"
module psr_ramp_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  psr_pkg::psr_item_t item_data,
  output logic               mid_take,
  input  logic               out_take,
  output logic               res_valid,
  output psr_pkg::psr_res_t  res_data
);

  localparam int MW = psr_pkg::MilliW;
  localparam int SumW = 34;

  logic                 valid_r;
  psr_pkg::psr_res_t    res_r;
  psr_pkg::psr_res_t    res_nxt;
  logic                 ramping_r, ramping_nxt;
  logic                 started_r, started_nxt;
  logic signed [MW-1:0] running_r, running_nxt;
  logic [31:0]          last_ms_r, last_ms_nxt;
  logic                 load;
  logic                 load_restart;
  logic [31:0]          elapsed_full;
  logic [15:0]          elapsed;
  logic [31:0]          mag;
  logic                 dir_down;
  logic signed [SumW-1:0] run_ext, mag_ext, tgt_ext, sum;
  logic                 step_pos;
  logic                 done;

  assign mid_take = !valid_r || out_take;
  assign load = item_valid && mid_take;
  assign load_restart = load && (item_data.kind == psr_pkg::KindRestart);

  // Step: |accel| times saturated elapsed ms, signed toward the target.
  always_comb begin
    elapsed_full = item_data.now_ms - last_ms_r;
    elapsed = (|elapsed_full[31:16]) ? psr_pkg::ElapsedMax : elapsed_full[15:0];
    mag = item_data.rate * elapsed;
    dir_down = running_r > item_data.target_milli;
    run_ext = SumW'(running_r);
    tgt_ext = SumW'(item_data.target_milli);
    mag_ext = $signed({2'b00, mag});
    sum = dir_down ? (run_ext - mag_ext) : (run_ext + mag_ext);
    step_pos = !dir_down && (mag != 32'd0);
    done = step_pos ? (sum >= tgt_ext) : (sum <= tgt_ext);
  end

  // Mode handling: restart, hold, first ramp tick, ramp tick.
  always_comb begin
    ramping_nxt = ramping_r;
    started_nxt = started_r;
    running_nxt = running_r;
    last_ms_nxt = last_ms_r;
    res_nxt.drive_valid = 1'b0;
    res_nxt.milli = '0;
    res_nxt.done = 1'b0;
    if (item_data.kind == psr_pkg::KindRestart) begin
      ramping_nxt = 1'b1;
      started_nxt = 1'b0;
    end else if (!ramping_r) begin
      if (item_data.hold_match) begin
        res_nxt.drive_valid = 1'b1;
        res_nxt.milli = item_data.target_milli;
      end else begin
        ramping_nxt = 1'b1;
      end
    end else if (!started_r) begin
      started_nxt = 1'b1;
      last_ms_nxt = item_data.now_ms;
      running_nxt = item_data.avg_milli;
    end else begin
      last_ms_nxt = item_data.now_ms;
      res_nxt.drive_valid = 1'b1;
      if (done) begin
        running_nxt = item_data.target_milli;
        started_nxt = 1'b0;
        ramping_nxt = 1'b0;
        res_nxt.done = 1'b1;
        res_nxt.milli = item_data.target_milli;
      end else begin
        // Not crossed yet, so the value stays between start and target.
        running_nxt = sum[MW-1:0];
        res_nxt.milli = sum[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ramping_r <= 1'b1;
      started_r <= 1'b0;
      running_r <= '0;
      last_ms_r <= '0;
    end else begin
      if (mid_take) begin
        valid_r <= item_valid;
      end
      if (load) begin
        ramping_r <= ramping_nxt;
        started_r <= started_nxt;
        running_r <= running_nxt;
        last_ms_r <= last_ms_nxt;
      end
    end
  end

  // Result payload follows each transfer into this stage.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res_data = res_r;

  // Hold mode is only entered with the ramp start cleared.
  `PSR_ASSERT_NOW(a_hold_not_started, clk, rst_n, !ramping_r, !started_r)
  // A restart always leaves ramp mode waiting for its first tick.
  `PSR_ASSERT_NEXT(a_restart_clears, clk, rst_n, load_restart, ramping_r && !started_r)
  // A finished ramp is always a commanded tick.
  `PSR_ASSERT_NOW(a_done_drives, clk, rst_n, valid_r && res_r.done, res_r.drive_valid)

endmodule

### rtl/psr_out_stage.sv
// Output register of the speed ramp: milli-PWM to PWM, truncated toward zero.
// Depends on psr_pkg.
module psr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  psr_pkg::psr_res_t res_data,
  output logic              out_take,
  output logic              out_valid,
  input  logic              out_stall,
  output psr_pkg::psr_out_t out_data
);

  localparam int MW = psr_pkg::MilliW;
  localparam int ProdW = (MW - 1) + 18;

  logic              valid_r;
  psr_pkg::psr_out_t out_r;
  psr_pkg::psr_out_t out_nxt;
  logic              neg;
  logic [MW-2:0]     mag;
  logic [ProdW-1:0]  prod;
  logic [7:0]        quot;

  assign out_take = !valid_r || !out_stall;

  // Divide the magnitude by 1000 with a scaled reciprocal, then restore sign.
  always_comb begin
    neg = res_data.milli[MW-1];
    mag = neg ? (MW-1)'(-res_data.milli) : res_data.milli[MW-2:0];
    prod = ProdW'(mag) * ProdW'(psr_pkg::Recip1000);
    quot = prod[psr_pkg::RecipShift +: 8];
    out_nxt.drive_valid = res_data.drive_valid;
    out_nxt.drive_pwm = neg ? $signed(-quot) : $signed(quot);
    out_nxt.ramp_done = res_data.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_take) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = out_r;

endmodule

### rtl/pwm_speed_ramp_core.sv
// Speed ramp generator for two wheels sharing one PWM command.
// Items enter on in_valid/in_stall with an in_data struct; each item gives
// exactly one result on out_valid/out_stall with an out_data struct.
// A restart item puts the block back in ramp mode. A control tick latches
// time and wheel average on the first ramp tick, then moves a running
// milli-PWM toward the target by |acceleration| times elapsed ms (capped at
// 65535 ms); on reaching the target it reports ramp_done and holds the
// target while the wheel average matches it.
// Path: each item passes through the input register, the ramp register and
// the output register in that order; a stall can hold it in any of them.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single ramp register that updates state each item.
// Reset (rst_n low, synchronous) empties all three registers and returns
// to ramp mode awaiting a first tick. When the receiver stalls, the result
// holds in the output register and the stall backs up stage by stage; new
// input transfers continue until every register is occupied.
// Depends on psr_pkg, psr_in_stage, psr_ramp_stage and psr_out_stage.
module pwm_speed_ramp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psr_pkg::psr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psr_pkg::psr_out_t out_data
);

  logic               item_valid;
  psr_pkg::psr_item_t item_data;
  logic               mid_take;
  logic               res_valid;
  psr_pkg::psr_res_t  res_data;
  logic               out_take;

  // Input register and preprocessing.
  psr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .mid_take   (mid_take),
    .item_valid (item_valid),
    .item_data  (item_data)
  );

  // Ramp state and step.
  psr_ramp_stage u_ramp (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_data  (item_data),
    .mid_take   (mid_take),
    .out_take   (out_take),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  // Divide to PWM and hold the result for the receiver.
  psr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for pwm_speed_ramp_core: directed ramp cases, then random ramps.
// Uses psr_pkg types; predicts every result in SystemVerilog and checks each out_data transfer.

module tb_top;

  localparam int AvgDivisor = 2;
  localparam int RandomItems = 1600;
  localparam int LongHoldCycles = 60;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  psr_pkg::psr_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  psr_pkg::psr_out_t out_data;

  // Predictor state: ramp mode, first tick seen, running milli-PWM, time stamp.
  bit                 in_ramp = 1'b1;
  bit                 ramp_armed = 1'b0;
  logic signed [39:0] ramp_milli = '0;
  logic [31:0]        ramp_stamp_ms = '0;

  // Drive commands still owed by the block, oldest first.
  psr_pkg::psr_out_t drive_expected[$];

  int          mismatches = 0;
  int          items_sent = 0;
  logic [31:0] clock_ms = '0;
  int          burst_left = 0;
  bit          no_idle = 1'b0;
  bit          hold_off_req = 1'b0;

  pwm_speed_ramp_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the drive command for one item and advances the ramp state.
  function automatic psr_pkg::psr_out_t predict_drive(psr_pkg::psr_in_t it);
    psr_pkg::psr_out_t res;
    int          target;
    int          avg_pwm;
    longint      target_milli;
    longint      cur;
    longint      rate;
    longint      step;
    longint      el;
    logic [31:0] elapsed;
    bit          done;
    res = '0;
    target = it.target_pwm;
    avg_pwm = (int'(it.left_pwm) + int'(it.right_pwm)) / AvgDivisor;
    target_milli = longint'(target) * psr_pkg::MilliPerUnit;
    if (it.kind == psr_pkg::KindRestart) begin
      in_ramp = 1'b1;
      ramp_armed = 1'b0;
      return res;
    end
    // Hold mode: keep driving the target while the wheels agree with it.
    if (!in_ramp) begin
      if (avg_pwm == target) begin
        res.drive_valid = 1'b1;
        res.drive_pwm = it.target_pwm;
      end else begin
        in_ramp = 1'b1;
      end
      return res;
    end
    // The first ramp tick only latches time and the wheel average.
    if (!ramp_armed) begin
      ramp_armed = 1'b1;
      ramp_stamp_ms = it.now_ms;
      ramp_milli = avg_pwm * psr_pkg::MilliPerUnit;
      return res;
    end
    elapsed = it.now_ms - ramp_stamp_ms;
    if (elapsed > psr_pkg::ElapsedMax) elapsed = psr_pkg::ElapsedMax;
    el = elapsed;
    cur = ramp_milli;
    rate = it.acceleration;
    if (rate < 0) rate = -rate;
    if (cur > target_milli) rate = -rate;
    step = rate * el;
    cur = cur + step;
    ramp_stamp_ms = it.now_ms;
    if (step > 0) done = (cur >= target_milli);
    else done = (cur <= target_milli);
    if (done) begin
      cur = target_milli;
      ramp_armed = 1'b0;
      in_ramp = 1'b0;
    end
    ramp_milli = cur;
    res.drive_valid = 1'b1;
    res.drive_pwm = 8'(cur / psr_pkg::MilliPerUnit);
    res.ramp_done = done;
    return res;
  endfunction

  function automatic void check_field(string field, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Record each input transfer's prediction and check each result transfer.
  always @(posedge clk) begin : monitor
    psr_pkg::psr_out_t want;
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0)
        drive_expected.push_back(predict_drive(in_data));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (drive_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                   $time, out_data.drive_valid, out_data.drive_pwm, out_data.ramp_done);
        end else begin
          want = drive_expected.pop_front();
          check_field("drive_valid", want.drive_valid, out_data.drive_valid);
          check_field("drive_pwm", want.drive_pwm, out_data.drive_pwm);
          check_field("ramp_done", want.ramp_done, out_data.ramp_done);
        end
      end
    end
  end

  // Receiver: stall patterns that change over time, plus a long hold-off on request.
  initial begin : receiver
    int hold_cnt;
    int mode_left;
    int stall_pct;
    hold_cnt = 0;
    mode_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_cnt = LongHoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    if (no_idle) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
    burst_left = $urandom_range(0, 15);
  endtask

  // Offers one item and returns at the edge of its transfer (or after the gap).
  task automatic send_item(input psr_pkg::psr_in_t item);
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    pace();
  endtask

  function automatic psr_pkg::psr_in_t tick_item(logic [31:0] now, int target, int accel,
                                                 int left, int right);
    psr_pkg::psr_in_t it;
    it.kind = psr_pkg::KindTick;
    it.now_ms = now;
    it.target_pwm = 8'(target);
    it.acceleration = 16'(accel);
    it.left_pwm = 8'(left);
    it.right_pwm = 8'(right);
    return it;
  endfunction

  function automatic psr_pkg::psr_in_t restart_item();
    psr_pkg::psr_in_t it;
    it = tick_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.kind = psr_pkg::KindRestart;
    return it;
  endfunction

  // Arbitrary item with every field random, the kind included.
  function automatic psr_pkg::psr_in_t noise_item();
    psr_pkg::psr_in_t it;
    it = tick_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.kind = $urandom_range(1) ? psr_pkg::KindRestart : psr_pkg::KindTick;
    return it;
  endfunction

  task automatic send_tick(int advance, int target, int accel, int left, int right);
    clock_ms = clock_ms + advance;
    send_item(tick_item(clock_ms, target, accel, left, right));
  endtask

  function automatic int pick_target();
    if ($urandom_range(7) == 0) return int'($urandom_range(255)) - 128;
    return int'($urandom_range(200)) - 100;
  endfunction

  function automatic int pick_accel();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1, 300);
      2: return $urandom_range(1, 5000);
      3: return -int'($urandom_range(1, 5000));
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic wait_for_drain();
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  // Ramp up from zero to the target over several ticks, ending with ramp_done.
  task automatic test_ramp_up();
    send_item(restart_item());
    clock_ms = 1000;
    send_tick(0, 50, 10, 0, 0);
    send_tick(1000, 50, 10, 0, 0);
    send_tick(3000, 50, 10, 0, 0);
    send_tick(2000, 50, 10, 0, 0);
  endtask

  // Hold mode: exact match, match after truncation, then a mismatch back to ramp mode.
  task automatic test_hold_mode();
    send_tick(5, 50, 10, 50, 50);
    send_tick(5, 50, 10, 51, 50);
    send_tick(5, 50, 10, 40, 50);
  endtask

  // Ramp down with a negative acceleration whose sign must be ignored.
  task automatic test_ramp_down();
    send_tick(5, -100, -32768, 127, 127);
    send_tick(1, -100, -32768, 127, 127);
    send_tick(10, -100, -32768, 127, 127);
  endtask

  // Elapsed time across the 32-bit wrap, then an interval past the saturation point.
  task automatic test_time_wrap();
    send_item(restart_item());
    clock_ms = 32'hFFFF_FFF0;
    send_tick(0, 127, 1, -128, -128);
    send_tick(32, 127, 1, 0, 0);
    send_tick(200000, 127, 1, 0, 0);
  endtask

  // Zero step: below the target it counts as reached; above it the value stays put.
  task automatic test_zero_step();
    send_tick(7, 127, 0, 0, 0);
    send_item(restart_item());
    send_tick(3, -100, 5, 100, 100);
    send_tick(0, -100, 5, 100, 100);
  endtask

  // Field extremes: full-scale PWMs and accelerations, saturated time.
  task automatic test_field_extremes();
    send_item(restart_item());
    send_tick(3, -128, 32767, 127, -128);
    send_tick(70000, -128, -32768, 0, 0);
    send_tick(1, -128, 0, -128, -128);
    send_tick(1, 127, 0, 127, 127);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    int i;
    no_idle = 1'b1;
    hold_off_req = 1'b1;
    for (i = 0; i < 30; i++)
      send_tick($urandom_range(0, 100), pick_target(), pick_accel(),
                int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128);
    no_idle = 1'b0;
  endtask

  // Sender pauses until every owed result has come out.
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    wait_for_drain();
  endtask

  // One ramp session: optional restart or time jump, then ticks with random content.
  task automatic run_ramp_session();
    int          target;
    int          accel;
    int          left;
    int          right;
    int          ticks;
    int          i;
    logic [31:0] step_ms;
    no_idle = ($urandom_range(4) == 0);
    target = pick_target();
    accel = pick_accel();
    ticks = $urandom_range(2, 12);
    case ($urandom_range(2))
      0: send_item(restart_item());
      1: clock_ms = $urandom;
      default: ;
    endcase
    for (i = 0; i < ticks; i++) begin
      if ($urandom_range(9) == 0) begin
        send_item(noise_item());
        continue;
      end
      if ($urandom_range(9) == 0) target = pick_target();
      if ($urandom_range(9) == 0) accel = pick_accel();
      case ($urandom_range(19))
        0: step_ms = $urandom_range(60000, 300000);
        1: step_ms = $urandom;
        2: step_ms = 0;
        default: step_ms = $urandom_range(1, 150);
      endcase
      // Later ticks mostly read back wheels that agree with the target.
      if (i > 0 && $urandom_range(3) != 0) begin
        left = target;
        right = target;
        if ($urandom_range(1) == 1) begin
          if (target >= 0 && target < 127) right = target + 1;
          else if (target < 0 && target > -128) right = target - 1;
        end
      end else if ($urandom_range(3) == 0) begin
        left = int'($urandom_range(255)) - 128;
        right = int'($urandom_range(255)) - 128;
      end else begin
        left = int'($urandom_range(200)) - 100;
        right = int'($urandom_range(200)) - 100;
      end
      send_tick(step_ms, target, accel, left, right);
    end
  endtask

  task automatic test_random_ramps();
    int start;
    start = items_sent;
    while (items_sent - start < RandomItems) run_ramp_session();
    no_idle = 1'b0;
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_ramp_up();
    test_hold_mode();
    test_ramp_down();
    test_time_wrap();
    test_zero_step();
    test_field_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_ramps();
    // Let the last results out, then allow for the pipeline depth.
    in_valid <= 1'b0;
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && drive_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### pwm_speed_ramp_core.f
+incdir+rtl
rtl/psr_pkg.sv
rtl/psr_in_stage.sv
rtl/psr_ramp_stage.sv
rtl/psr_out_stage.sv
rtl/pwm_speed_ramp_core.sv
tb/tb_top.sv
